@@ rtl/dsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Shared sizes, request and response types, and codes for the allocator core.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int SLOTS       = 64;
   localparam int HANDLE_BITS = 16;
   localparam int SLOT_IDX_W  = $clog2(SLOTS);
   localparam int SLOT_CNT_W  = $clog2(SLOTS + 1);
   localparam int LIMIT_W     = 7;
   localparam int LIMIT_RESET = 64;

   typedef enum logic [1:0] {
      ACT_INSTALL = 2'd0,
      ACT_CLOSE   = 2'd1,
      ACT_LOOKUP  = 2'd2,
      ACT_SWEEP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BAD_FD = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSTALL,
      ST_ACCESS_READ,
      ST_ACCESS_RESP,
      ST_SWEEP_SCAN,
      ST_SWEEP_READ,
      ST_SWEEP_DONE
   } sm_state_type;

   typedef struct packed {
      action_type             action;
      logic [HANDLE_BITS-1:0] file_handle;
      logic [5:0]             lower_bound;
      logic                   close_on_exec;
      logic [5:0]             slot_index;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [5:0]             slot_out;
      logic [HANDLE_BITS-1:0] handle_out;
      logic                   handle_released;
      logic                   last;
   } rsp_type;

endpackage

@@ rtl/descriptor_slot_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Descriptor slot allocator core
// Table of descriptor slots with install, close, lookup and close-on-exec sweep.
// ----------------------------------------------------------------------------
// One request is handled at a time, and req_stall stays high until its last
// response has been produced. A single sequencer walks the table slot by slot
// over the single-port handle memory: install examines slots from lower_bound
// upwards until it finds a free one or reaches the open limit, close and
// lookup read the handle of the addressed slot and then respond, and a sweep
// scans every slot, reading the handle of each one it frees. Output
// back-pressure can hold any response. The open limit may be written through
// the csr port whenever csr_ready is high; the table is empty after reset.
module descriptor_slot_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dsa_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dsa_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dsa_pkg::LIMIT_W-1:0]   csr_data
);
   import dsa_pkg::*;

   sm_state_type            state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [SLOTS-1:0]        slot_valid_ff, slot_valid_in;
   logic [SLOTS-1:0]        exec_flags_ff, exec_flags_in;
   logic [LIMIT_W-1:0]      open_limit_ff;
   logic [SLOT_CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic                    pending_valid_ff, pending_valid_in;
   logic [SLOT_IDX_W-1:0]   pending_slot_ff, pending_slot_in;
   logic [HANDLE_BITS-1:0]  pending_handle_ff, pending_handle_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [HANDLE_BITS-1:0]  handle_mem [SLOTS];
   logic [HANDLE_BITS-1:0]  rd_data_ff;
   logic [SLOT_IDX_W-1:0]   rd_addr;
   logic                    mem_we;

   logic                    req_accept;
   logic                    out_free;
   logic                    emit;
   logic [SLOT_CNT_W-1:0]   eff_limit;
   logic [SLOT_IDX_W-1:0]   scan_slot;
   logic [SLOT_IDX_W-1:0]   access_slot;
   logic                    scan_end;
   logic                    in_limit;
   logic                    scan_hit;
   logic                    access_ok;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign eff_limit   = (open_limit_ff < LIMIT_W'(SLOTS)) ?
                        SLOT_CNT_W'(open_limit_ff) : SLOT_CNT_W'(SLOTS);
   assign scan_slot   = scan_idx_ff[SLOT_IDX_W-1:0];
   assign access_slot = req_ff.slot_index[SLOT_IDX_W-1:0];
   assign scan_end    = (scan_idx_ff >= SLOT_CNT_W'(SLOTS));
   assign in_limit    = (scan_idx_ff < eff_limit);
   assign scan_hit    = !scan_end && slot_valid_ff[scan_slot] && exec_flags_ff[scan_slot];
   assign access_ok   = ({1'b0, req_ff.slot_index} < 7'(SLOTS)) && slot_valid_ff[access_slot];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.action)
                  ACT_INSTALL: state_in = ST_INSTALL;
                  ACT_CLOSE:   state_in = ST_ACCESS_READ;
                  ACT_LOOKUP:  state_in = ST_ACCESS_READ;
                  ACT_SWEEP:   state_in = ST_SWEEP_SCAN;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_INSTALL: begin
            if (out_free && (!in_limit || !slot_valid_ff[scan_slot])) begin
               state_in = ST_IDLE;
            end
         end
         ST_ACCESS_READ: state_in = ST_ACCESS_RESP;
         ST_ACCESS_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP_SCAN: begin
            if (scan_end) begin
               state_in = ST_SWEEP_DONE;
            end else if (scan_hit && (!pending_valid_ff || out_free)) begin
               state_in = ST_SWEEP_READ;
            end
         end
         ST_SWEEP_READ: state_in = ST_SWEEP_SCAN;
         ST_SWEEP_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in            = req_ff;
      slot_valid_in     = slot_valid_ff;
      exec_flags_in     = exec_flags_ff;
      scan_idx_in       = scan_idx_ff;
      pending_valid_in  = pending_valid_ff;
      pending_slot_in   = pending_slot_ff;
      pending_handle_in = pending_handle_ff;
      rsp_data_in       = rsp_data_ff;
      emit              = 1'b0;
      mem_we            = 1'b0;
      rd_addr           = (state_ff inside {ST_ACCESS_READ, ST_ACCESS_RESP}) ?
                          access_slot : scan_slot;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in           = req_data;
               pending_valid_in = 1'b0;
               scan_idx_in      = (req_data.action == ACT_INSTALL) ?
                                  SLOT_CNT_W'(req_data.lower_bound) : '0;
            end
         end
         ST_INSTALL: begin
            if (!in_limit) begin
               if (out_free) begin
                  emit        = 1'b1;
                  rsp_data_in = '{STATUS_FULL, 6'd0, '0, 1'b0, 1'b1};
               end
            end else if (!slot_valid_ff[scan_slot]) begin
               if (out_free) begin
                  emit                     = 1'b1;
                  mem_we                   = 1'b1;
                  slot_valid_in[scan_slot] = 1'b1;
                  exec_flags_in[scan_slot] = req_ff.close_on_exec;
                  rsp_data_in = '{STATUS_OK, 6'(scan_slot), req_ff.file_handle, 1'b0, 1'b1};
               end
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_ACCESS_RESP: begin
            if (out_free) begin
               emit = 1'b1;
               if (access_ok) begin
                  rsp_data_in = '{STATUS_OK, req_ff.slot_index, rd_data_ff,
                                  req_ff.action == ACT_CLOSE, 1'b1};
                  if (req_ff.action == ACT_CLOSE) begin
                     slot_valid_in[access_slot] = 1'b0;
                     exec_flags_in[access_slot] = 1'b0;
                  end
               end else begin
                  rsp_data_in = '{STATUS_BAD_FD, 6'd0, '0, 1'b0, 1'b1};
               end
            end
         end
         ST_SWEEP_SCAN: begin
            if (scan_hit) begin
               if (!pending_valid_ff || out_free) begin
                  if (pending_valid_ff) begin
                     emit        = 1'b1;
                     rsp_data_in = '{STATUS_OK, 6'(pending_slot_ff), pending_handle_ff,
                                     1'b1, 1'b0};
                  end
                  pending_slot_in          = scan_slot;
                  slot_valid_in[scan_slot] = 1'b0;
                  exec_flags_in[scan_slot] = 1'b0;
               end
            end else if (!scan_end) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_SWEEP_READ: begin
            pending_valid_in  = 1'b1;
            pending_handle_in = rd_data_ff;
            scan_idx_in       = scan_idx_ff + 1'b1;
         end
         ST_SWEEP_DONE: begin
            if (out_free) begin
               emit             = 1'b1;
               pending_valid_in = 1'b0;
               if (pending_valid_ff) begin
                  rsp_data_in = '{STATUS_OK, 6'(pending_slot_ff), pending_handle_ff,
                                  1'b1, 1'b1};
               end else begin
                  rsp_data_in = '{STATUS_OK, 6'd0, '0, 1'b0, 1'b1};
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         handle_mem[scan_slot] <= req_ff.file_handle;
      end
      rd_data_ff <= handle_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      req_ff            <= req_in;
      scan_idx_ff       <= scan_idx_in;
      pending_slot_ff   <= pending_slot_in;
      pending_handle_ff <= pending_handle_in;
      rsp_data_ff       <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         slot_valid_ff    <= '0;
         exec_flags_ff    <= '0;
         open_limit_ff    <= LIMIT_W'(LIMIT_RESET);
         pending_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         slot_valid_ff    <= slot_valid_in;
         exec_flags_ff    <= exec_flags_in;
         pending_valid_ff <= pending_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            open_limit_ff <= csr_data;
         end
      end
   end

   // A close-on-exec flag is only ever held by an occupied slot.
   assert property (@(posedge clock) disable iff (reset)
      (exec_flags_ff & ~slot_valid_ff) == '0)
      else $error("close-on-exec flag set on a free slot");

   // A new response is only produced when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("response produced while the output register is held");

   assert property (@(posedge clock) disable iff (reset)
      pending_valid_ff |-> (state_ff == ST_SWEEP_SCAN || state_ff == ST_SWEEP_READ ||
                            state_ff == ST_SWEEP_DONE))
      else $error("sweep result pending outside a sweep");

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start the sequencer");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (scan_idx_ff <= SLOT_CNT_W'(SLOTS)))
      else $error("scan index ran past the table");

endmodule

@@ tb/sv/descriptor_table_checker.sv @@
// ----------------------------------------------------------------------------
// Descriptor table checker
// Watches the request, response and csr channels of the allocator core, keeps
// its own copy of the slot table and open limit, works out the responses that
// each accepted request must produce and compares them field by field.
// ----------------------------------------------------------------------------
module descriptor_table_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  dsa_pkg::req_type            req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  dsa_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [dsa_pkg::LIMIT_W-1:0] csr_data,
   output int                          error_count,
   output int                          outstanding
);
   import dsa_pkg::*;

   logic [HANDLE_BITS-1:0] slot_handles [SLOTS];
   logic [SLOTS-1:0]       slot_in_use;
   logic [SLOTS-1:0]       slot_cloexec;
   logic [SLOTS-1:0]       sweep_victims;
   logic [LIMIT_W-1:0]     allocation_limit;
   rsp_type                expected_responses [$];
   rsp_type                want;
   int                     effective_limit;
   int                     sweep_left;
   int                     response_count = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         slot_in_use = '0;
         slot_cloexec = '0;
         allocation_limit = LIMIT_W'(LIMIT_RESET);
         expected_responses.delete();
         for (int s = 0; s < SLOTS; s++) begin
            slot_handles[s] = '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            allocation_limit = csr_data;
         end

         if (req_valid && !req_stall) begin
            want = '0;
            want.status = STATUS_OK;
            want.last = 1'b1;
            case (req_data.action)
               ACT_INSTALL: begin
                  effective_limit = (allocation_limit < SLOTS) ? int'(allocation_limit) : SLOTS;
                  want.status = STATUS_FULL;
                  for (int s = int'(req_data.lower_bound); s < effective_limit; s++) begin
                     if (want.status == STATUS_FULL && !slot_in_use[s]) begin
                        slot_in_use[s] = 1'b1;
                        slot_cloexec[s] = req_data.close_on_exec;
                        slot_handles[s] = req_data.file_handle;
                        want.status = STATUS_OK;
                        want.slot_out = 6'(s);
                        want.handle_out = req_data.file_handle;
                     end
                  end
                  expected_responses.push_back(want);
               end
               ACT_CLOSE, ACT_LOOKUP: begin
                  if (!slot_in_use[req_data.slot_index]) begin
                     want.status = STATUS_BAD_FD;
                  end else begin
                     want.slot_out = req_data.slot_index;
                     want.handle_out = slot_handles[req_data.slot_index];
                     if (req_data.action == ACT_CLOSE) begin
                        want.handle_released = 1'b1;
                        slot_in_use[req_data.slot_index] = 1'b0;
                        slot_cloexec[req_data.slot_index] = 1'b0;
                     end
                  end
                  expected_responses.push_back(want);
               end
               default: begin
                  sweep_victims = slot_in_use & slot_cloexec;
                  sweep_left = $countones(sweep_victims);
                  if (sweep_left == 0) begin
                     expected_responses.push_back(want);
                  end
                  for (int s = 0; s < SLOTS; s++) begin
                     if (sweep_victims[s]) begin
                        sweep_left--;
                        want.slot_out = 6'(s);
                        want.handle_out = slot_handles[s];
                        want.handle_released = 1'b1;
                        want.last = (sweep_left == 0);
                        expected_responses.push_back(want);
                     end
                  end
                  slot_in_use &= ~sweep_victims;
                  slot_cloexec &= ~sweep_victims;
               end
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (expected_responses.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                         response_count));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                            response_count, rsp_data.status, want.status));
               if (rsp_data.slot_out !== want.slot_out)
                  report_mismatch($sformatf("response %0d slot_out %0d, expected %0d",
                                            response_count, rsp_data.slot_out, want.slot_out));
               if (rsp_data.handle_out !== want.handle_out)
                  report_mismatch($sformatf("response %0d handle_out %h, expected %h",
                                            response_count, rsp_data.handle_out,
                                            want.handle_out));
               if (rsp_data.handle_released !== want.handle_released)
                  report_mismatch($sformatf("response %0d handle_released %b, expected %b",
                                            response_count, rsp_data.handle_released,
                                            want.handle_released));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("response %0d last %b, expected %b",
                                            response_count, rsp_data.last, want.last));
            end
         end
      end
      outstanding = expected_responses.size();
   end

endmodule

@@ tb/sv/tb_descriptor_slot_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Descriptor slot allocator core testbench
// Drives directed and random install, close, lookup and sweep requests through
// several open limit settings with bursty input and a patterned output stall;
// the checker predicts every response and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_descriptor_slot_allocator_core;
   import dsa_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_data = '0;
   int                 error_count;
   int                 outstanding;
   int                 burst_left = 0;
   int                 hold_requests = 0;
   int                 holds_served = 0;

   descriptor_slot_allocator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   descriptor_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #12_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic req_type make_request(input action_type act,
                                            input logic [HANDLE_BITS-1:0] handle,
                                            input logic [5:0] lower,
                                            input logic cloexec,
                                            input logic [5:0] idx);
      req_type item;
      item.action = act;
      item.file_handle = handle;
      item.lower_bound = lower;
      item.close_on_exec = cloexec;
      item.slot_index = idx;
      return item;
   endfunction

   task automatic send_request(input req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Output stall: random patterns in spans, plus a long hold-off on request.
   initial begin
      int mode;
      int span_left;
      int hold_left;
      mode = 0;
      span_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = 300;
         end
         if (span_left == 0) begin
            mode = $urandom_range(0, 3);
            span_left = $urandom_range(10, 60);
         end
         span_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin
      int phase_limit [7] = '{0, 1, 127, 63, 0, 0, 8};
      int phase_items [7] = '{30, 30, 75, 40, 45, 45, 45};
      int phase_install [7] = '{50, 50, 90, 45, 45, 45, 50};
      int phase_sweep [7] = '{10, 10, 0, 15, 15, 15, 10};
      bit phase_hold [7] = '{0, 0, 1, 0, 1, 0, 0};
      int roll;
      action_type act;
      logic [5:0] lower;
      logic [5:0] idx;

      phase_limit[4] = $urandom_range(2, 64);
      phase_limit[5] = $urandom_range(65, 126);

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_limit(LIMIT_W'(64));
      send_request(make_request(ACT_SWEEP, 16'h0000, 6'd0, 1'b0, 6'd0));
      send_request(make_request(ACT_LOOKUP, 16'h0000, 6'd0, 1'b0, 6'd0));
      send_request(make_request(ACT_CLOSE, 16'hFFFF, 6'd63, 1'b1, 6'd63));
      send_request(make_request(ACT_INSTALL, 16'hFFFF, 6'd0, 1'b1, 6'd63));
      send_request(make_request(ACT_INSTALL, 16'h0000, 6'd63, 1'b0, 6'd0));
      send_request(make_request(ACT_INSTALL, 16'hAAAA, 6'd63, 1'b1, 6'd0));
      send_request(make_request(ACT_LOOKUP, 16'h0000, 6'd0, 1'b0, 6'd63));
      send_request(make_request(ACT_LOOKUP, 16'hFFFF, 6'd63, 1'b1, 6'd0));
      send_request(make_request(ACT_INSTALL, 16'h5555, 6'd0, 1'b0, 6'd0));
      send_request(make_request(ACT_INSTALL, 16'h1234, 6'd0, 1'b1, 6'd0));
      send_request(make_request(ACT_CLOSE, 16'h0000, 6'd0, 1'b0, 6'd1));
      send_request(make_request(ACT_CLOSE, 16'h0000, 6'd0, 1'b0, 6'd1));
      send_request(make_request(ACT_INSTALL, 16'hBEEF, 6'd0, 1'b1, 6'd0));
      send_request(make_request(ACT_SWEEP, 16'h0000, 6'd0, 1'b0, 6'd0));
      send_request(make_request(ACT_LOOKUP, 16'h0000, 6'd0, 1'b0, 6'd2));
      send_request(make_request(ACT_SWEEP, 16'h0000, 6'd0, 1'b0, 6'd0));
      send_request(make_request(ACT_CLOSE, 16'h0000, 6'd0, 1'b0, 6'd63));

      for (int p = 0; p < 7; p++) begin
         drain_and_settle();
         write_limit(LIMIT_W'(phase_limit[p]));
         if (phase_hold[p]) begin
            hold_requests++;
         end
         for (int n = 0; n < phase_items[p]; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < phase_install[p]) begin
               act = ACT_INSTALL;
            end else if (roll < phase_install[p] + phase_sweep[p]) begin
               act = ACT_SWEEP;
            end else begin
               act = ($urandom_range(0, 1) == 0) ? ACT_CLOSE : ACT_LOOKUP;
            end
            lower = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 7))
                                               : 6'($urandom_range(0, 63));
            idx = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 15))
                                             : 6'($urandom_range(0, 63));
            send_request(make_request(act, 16'($urandom), lower, 1'($urandom), idx));
         end
         if (phase_install[p] >= 90) begin
            send_request(make_request(ACT_SWEEP, 16'h0000, 6'd0, 1'b0, 6'd0));
         end
      end

      drain_and_settle();
      repeat (100) @(negedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
